// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/ogru_pkg.sv -----
// Package: shared types, constants and codes of the occupancy grid ray update
`timescale 1ns / 1ps
package ogru_pkg;

   localparam int MAP_CELLS_DEF  = 64;
   localparam int MAP_CENTER_DEF = 32;
   localparam int CELL_BITS_DEF  = 16;
   localparam int HIT_GAIN       = 10;

   localparam int PT_W    = 20;
   localparam int COL_W   = 6;
   localparam int IDX_OUT_W = 32;
   localparam int SIN_W   = 16;
   localparam int POS_W   = 24;
   localparam int CS_W    = 16;
   localparam int PROD_W  = PT_W + SIN_W;
   localparam int ACC_W   = PROD_W + 1;
   localparam int DIV_W   = 26;
   localparam int Q_W     = 28;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_FREE = 2'd1,
      KIND_OCC  = 2'd2,
      KIND_DROP = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_HEADING_SIN  = 3'd0,
      REG_HEADING_COS  = 3'd1,
      REG_ROBOT_X_MM   = 3'd2,
      REG_ROBOT_Y_MM   = 3'd3,
      REG_CELL_SIZE_MM = 3'd4
   } reg_idx_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_WORLD,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_CHECK,
      ST_SETUP,
      ST_HIT_RD,
      ST_WRITE,
      ST_STEP,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic signed [SIN_W-1:0] heading_sin;
      logic signed [SIN_W-1:0] heading_cos;
      logic signed [POS_W-1:0] robot_x_mm;
      logic signed [POS_W-1:0] robot_y_mm;
      logic [CS_W-1:0]         cell_size_mm;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0]     cell_col;
      logic [COL_W-1:0]     cell_row;
      logic [1:0]           event_kind;
      logic [IDX_OUT_W-1:0] event_index;
      logic                 last_of_point;
      logic                 scan_done;
   } rsp_payload_type;

   typedef struct packed {
      logic clear_wr;
      logic load;
      logic mul;
      logic world;
      logic div_start;
      logic div_store;
      logic check;
      logic drop;
      logic setup;
      logic hit_rd;
      logic write;
      logic step;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic mul_last;
      logic div_done;
      logic div_last;
      logic item_ok;
      logic wr_ok;
      logic hit_mode;
      logic walk_end;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/ogru_if.sv -----
// Interfaces: scan point request channel and cell event response channel
`timescale 1ns / 1ps
interface ogru_req_if;
   import ogru_pkg::*;
   logic                   valid;
   logic                   ready;
   logic signed [PT_W-1:0] point_x_mm;
   logic signed [PT_W-1:0] point_y_mm;
   logic                   point_valid;
   logic                   end_of_scan;

   modport source (output valid, point_x_mm, point_y_mm, point_valid, end_of_scan,
                   input ready);
   modport sink (input valid, point_x_mm, point_y_mm, point_valid, end_of_scan,
                 output ready);
endinterface

interface ogru_rsp_if;
   import ogru_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [COL_W-1:0]     cell_col;
   logic [COL_W-1:0]     cell_row;
   logic [1:0]           event_kind;
   logic [IDX_OUT_W-1:0] event_index;
   logic                 last_of_point;
   logic                 scan_done;

   modport source (output valid, cell_col, cell_row, event_kind, event_index,
                   last_of_point, scan_done, input ready);
   modport sink (input valid, cell_col, cell_row, event_kind, event_index,
                 last_of_point, scan_done, output ready);
endinterface

// ----- rtl/ogru_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module ogru_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/ogru_div.sv -----
// Floor divider: signed dividend by unsigned divisor, one quotient bit per cycle
`timescale 1ns / 1ps
module ogru_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [ogru_pkg::DIV_W-1:0] dividend,
   input  logic [ogru_pkg::CS_W-1:0]      divisor,
   output logic                           done,
   output logic signed [ogru_pkg::Q_W-1:0] quotient
);
   import ogru_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic [CS_W-1:0]  dsr_ff, dsr_in;
   logic [CS_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;

   logic [CS_W:0]    trial;
   logic             fits;
   logic [Q_W-1:0]   q_mag;
   logic [Q_W-1:0]   q_up;

   // One restoring step
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[DIV_W-1];
         dsr_in  = (divisor == '0) ? CS_W'(1) : divisor;
         rem_in  = '0;
         quo_in  = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
      end else if (busy_ff) begin
         rem_in = fits ? CS_W'(trial - {1'b0, dsr_ff}) : CS_W'(trial);
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // Round toward minus infinity for negative dividends
   assign q_mag    = Q_W'(quo_ff);
   assign q_up     = q_mag + Q_W'(rem_ff != '0);
   assign quotient = neg_ff ? $signed(-q_up) : $signed(q_mag);
   assign done     = done_ff;
endmodule

// ----- rtl/ogru_dp.sv -----
// Datapath: transform, cell division, map memory, line walk and result staging
`timescale 1ns / 1ps
module ogru_dp #(
   parameter int MAP_CELLS  = ogru_pkg::MAP_CELLS_DEF,
   parameter int MAP_CENTER = ogru_pkg::MAP_CENTER_DEF,
   parameter int CELL_BITS  = ogru_pkg::CELL_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ogru_pkg::ctrl_cmd_type          cmd,
   output ogru_pkg::dp_status_type         sts,
   input  ogru_pkg::cfg_type               cfg,
   input  logic signed [ogru_pkg::PT_W-1:0] req_point_x_mm,
   input  logic signed [ogru_pkg::PT_W-1:0] req_point_y_mm,
   input  logic                            req_point_valid,
   input  logic                            req_end_of_scan,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ogru_pkg::rsp_payload_type       rsp_data
);
   import ogru_pkg::*;

   localparam int IDX_W  = $clog2(MAP_CELLS);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int E_W    = IDX_W + 1;
   localparam int N_W    = IDX_W + 1;
   localparam int SW     = CELL_BITS + 5;
   localparam logic signed [SW-1:0] SAT_HI =
      {{(SW - CELL_BITS + 1){1'b0}}, {(CELL_BITS - 1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

   function automatic logic on_map(input logic signed [Q_W-1:0] c);
      on_map = !c[Q_W-1] && (c < Q_W'(MAP_CELLS));
   endfunction

   // Item registers
   logic signed [PT_W-1:0] px_ff, py_ff;
   logic                   valid_ff, eos_ff;

   // Transform registers
   logic [2:0]               mul_cnt_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  accx_ff, accy_ff;
   logic signed [DIV_W-1:0]  wx_ff, nwy_ff;

   // Division registers
   logic [1:0]             div_idx_ff;
   logic signed [Q_W-1:0]  q_ff [4];
   logic signed [DIV_W-1:0] div_dividend;
   logic                    div_done;
   logic signed [Q_W-1:0]   div_quotient;

   // Cell and walk registers
   logic [IDX_W-1:0] end_col_ff, end_row_ff, rob_col_ff, rob_row_ff;
   logic [IDX_W-1:0] maj_ff, min_ff, amaj_ff, amin_ff, i_ff;
   logic [IDX_W-1:0] cur_col_ff, cur_row_ff;
   logic [E_W-1:0]   e_ff;
   logic             x_major_ff, maj_neg_ff, min_neg_ff, first_ff;
   logic             end_ff, hit_mode_ff;

   // Event registers
   logic [ADDR_W-1:0]    clr_cnt_ff;
   logic [N_W-1:0]       n_ff;
   logic [IDX_OUT_W-1:0] free_cnt_ff, occ_cnt_ff;
   rsp_payload_type      pend_ff, out_ff;
   logic                 pend_v_ff, out_v_ff;

   // Combinational
   logic signed [PT_W-1:0]   mul_a;
   logic signed [SIN_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] mul_res;
   logic signed [Q_W-1:0]    c_col, c_row, c_rcol, c_rrow;
   logic signed [IDX_W:0]    dx, dy;
   logic [IDX_W-1:0]         adx, ady;
   logic [IDX_W-1:0]         maj_step, min_step, i_step, col_step, row_step;
   logic [E_W-1:0]           e_sum, e_step;
   logic                     adv;
   logic [ADDR_W-1:0]        rd_addr, wr_addr, ram_wr_addr;
   logic [CELL_BITS-1:0]     ram_rd_data, ram_wr_data;
   logic                     ram_we;
   logic signed [CELL_BITS-1:0] cell_old, after;
   logic signed [SW-1:0]     delta, sum;
   logic                     evt_occ, evt_free, evt;
   logic [IDX_W-1:0]         wr_col, wr_row;
   rsp_payload_type          evt_data, fin_data, drop_data;

   // Multiplier operand select
   always_comb begin
      case (mul_cnt_ff)
         3'd0:    begin mul_a = px_ff; mul_b = cfg.heading_cos; end
         3'd1:    begin mul_a = py_ff; mul_b = cfg.heading_sin; end
         3'd2:    begin mul_a = px_ff; mul_b = cfg.heading_sin; end
         default: begin mul_a = py_ff; mul_b = cfg.heading_cos; end
      endcase
   end
   assign mul_res = mul_a * mul_b;

   // Rotate and translate
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff      <= req_point_x_mm;
         py_ff      <= req_point_y_mm;
         valid_ff   <= req_point_valid;
         eos_ff     <= req_end_of_scan;
         mul_cnt_ff <= '0;
      end else if (cmd.mul) begin
         mul_cnt_ff <= mul_cnt_ff + 3'd1;
         prod_ff    <= mul_res;
         case (mul_cnt_ff)
            3'd1:    accx_ff <= ACC_W'(prod_ff) + ACC_W'(16384);
            3'd2:    accx_ff <= accx_ff - ACC_W'(prod_ff);
            3'd3:    accy_ff <= ACC_W'(prod_ff) + ACC_W'(16384);
            3'd4:    accy_ff <= accy_ff + ACC_W'(prod_ff);
            default: accx_ff <= accx_ff;
         endcase
      end
      if (cmd.world) begin
         wx_ff  <= DIV_W'($signed(accx_ff[ACC_W-1:15])) + DIV_W'($signed(cfg.robot_x_mm));
         nwy_ff <= -(DIV_W'($signed(accy_ff[ACC_W-1:15])) +
                     DIV_W'($signed(cfg.robot_y_mm)));
      end
   end

   // Divide world and robot coordinates by the cell size
   always_comb begin
      case (div_idx_ff)
         2'd0:    div_dividend = wx_ff;
         2'd1:    div_dividend = nwy_ff;
         2'd2:    div_dividend = DIV_W'($signed(cfg.robot_x_mm));
         default: div_dividend = -DIV_W'($signed(cfg.robot_y_mm));
      endcase
   end

   ogru_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (cfg.cell_size_mm),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         div_idx_ff <= '0;
      end else if (cmd.div_store) begin
         q_ff[div_idx_ff] <= div_quotient;
         div_idx_ff       <= div_idx_ff + 2'd1;
      end
   end

   // Cells and the map check
   assign c_col  = q_ff[0] + Q_W'(MAP_CENTER);
   assign c_row  = q_ff[1] + Q_W'(MAP_CENTER);
   assign c_rcol = q_ff[2] + Q_W'(MAP_CENTER);
   assign c_rrow = q_ff[3] + Q_W'(MAP_CENTER);

   // Walk setup terms
   assign dx  = $signed({1'b0, end_col_ff}) - $signed({1'b0, rob_col_ff});
   assign dy  = $signed({1'b0, end_row_ff}) - $signed({1'b0, rob_row_ff});
   assign adx = dx[IDX_W] ? IDX_W'(-dx) : IDX_W'(dx);
   assign ady = dy[IDX_W] ? IDX_W'(-dy) : IDX_W'(dy);

   // Next walk cell
   assign maj_step = first_ff ? maj_ff :
                     (maj_neg_ff ? maj_ff - IDX_W'(1) : maj_ff + IDX_W'(1));
   assign i_step   = first_ff ? '0 : i_ff + IDX_W'(1);
   assign e_sum    = e_ff + E_W'(amin_ff);
   assign adv      = e_sum > E_W'(amaj_ff);
   assign e_step   = adv ? e_sum - E_W'(amaj_ff) : e_sum;
   assign min_step = !adv ? min_ff :
                     (min_neg_ff ? min_ff - IDX_W'(1) : min_ff + IDX_W'(1));
   assign col_step = x_major_ff ? maj_step : min_step;
   assign row_step = x_major_ff ? min_step : maj_step;

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         end_col_ff <= c_col[IDX_W-1:0];
         end_row_ff <= c_row[IDX_W-1:0];
         rob_col_ff <= c_rcol[IDX_W-1:0];
         rob_row_ff <= c_rrow[IDX_W-1:0];
      end
      if (cmd.setup) begin
         x_major_ff <= adx > ady;
         maj_ff     <= (adx > ady) ? rob_col_ff : rob_row_ff;
         min_ff     <= (adx > ady) ? rob_row_ff : rob_col_ff;
         amaj_ff    <= (adx > ady) ? adx : ady;
         amin_ff    <= (adx > ady) ? ady : adx;
         maj_neg_ff <= (adx > ady) ? dx[IDX_W] : dy[IDX_W];
         min_neg_ff <= (adx > ady) ? dy[IDX_W] : dx[IDX_W];
         e_ff       <= '0;
         i_ff       <= '0;
         first_ff   <= 1'b1;
      end else if (cmd.step) begin
         maj_ff     <= maj_step;
         min_ff     <= min_step;
         e_ff       <= e_step;
         i_ff       <= i_step;
         first_ff   <= 1'b0;
         cur_col_ff <= col_step;
         cur_row_ff <= row_step;
         end_ff     <= i_step == amaj_ff;
      end
   end

   // Map memory ports
   assign rd_addr     = cmd.hit_rd ? {end_row_ff, end_col_ff} : {row_step, col_step};
   assign wr_col      = hit_mode_ff ? end_col_ff : cur_col_ff;
   assign wr_row      = hit_mode_ff ? end_row_ff : cur_row_ff;
   assign wr_addr     = {wr_row, wr_col};
   assign ram_we      = cmd.clear_wr || cmd.write;
   assign ram_wr_addr = cmd.clear_wr ? clr_cnt_ff : wr_addr;
   assign ram_wr_data = cmd.clear_wr ? '0 : after;

   ogru_ram #(
      .WIDTH (CELL_BITS),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .we      (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.hit_rd || cmd.step),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // Saturating cell update and event detection
   assign cell_old = $signed(ram_rd_data);
   assign delta    = hit_mode_ff ? SW'(HIT_GAIN) : (end_ff ? SW'(1) : -SW'(1));
   assign sum      = SW'(cell_old) + delta;
   always_comb begin
      if (sum > SAT_HI) begin
         after = CELL_BITS'(SAT_HI);
      end else if (sum < SAT_LO) begin
         after = CELL_BITS'(SAT_LO);
      end else begin
         after = CELL_BITS'(sum);
      end
   end

   assign evt_occ  = (hit_mode_ff ? (cell_old[CELL_BITS-1] || cell_old == '0) :
                      cell_old == '0) && !after[CELL_BITS-1] && after != '0;
   assign evt_free = !hit_mode_ff && cell_old == '0 && after[CELL_BITS-1];
   assign evt      = (evt_occ || evt_free) && (n_ff < N_W'(MAP_CELLS));

   always_comb begin
      evt_data               = '0;
      evt_data.cell_col      = COL_W'(wr_col);
      evt_data.cell_row      = COL_W'(wr_row);
      evt_data.event_kind    = evt_free ? KIND_FREE : KIND_OCC;
      evt_data.event_index   = evt_free ? free_cnt_ff : occ_cnt_ff;
      drop_data              = '0;
      drop_data.event_kind   = KIND_DROP;
      fin_data               = pend_v_ff ? pend_ff : '0;
      if (!pend_v_ff) begin
         fin_data.cell_col   = COL_W'(end_col_ff);
         fin_data.cell_row   = COL_W'(end_row_ff);
         fin_data.event_kind = KIND_NONE;
      end
      fin_data.last_of_point = 1'b1;
      fin_data.scan_done     = eos_ff;
   end

   // Control state of the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         free_cnt_ff <= '0;
         occ_cnt_ff  <= '0;
         pend_v_ff   <= 1'b0;
         out_v_ff    <= 1'b0;
         hit_mode_ff <= 1'b0;
         n_ff        <= '0;
      end else begin
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         end
         if (cmd.hit_rd) begin
            hit_mode_ff <= 1'b1;
         end else if (cmd.step) begin
            hit_mode_ff <= 1'b0;
         end
         if (out_v_ff && rsp_ready) begin
            out_v_ff <= 1'b0;
         end
         if (cmd.load) begin
            n_ff      <= '0;
            pend_v_ff <= 1'b0;
         end else if (cmd.drop) begin
            pend_ff   <= drop_data;
            pend_v_ff <= 1'b1;
         end else if (cmd.write && evt) begin
            if (pend_v_ff) begin
               out_ff   <= pend_ff;
               out_v_ff <= 1'b1;
            end
            pend_ff   <= evt_data;
            pend_v_ff <= 1'b1;
            n_ff      <= n_ff + N_W'(1);
            if (evt_free) begin
               free_cnt_ff <= free_cnt_ff + IDX_OUT_W'(1);
            end else begin
               occ_cnt_ff <= occ_cnt_ff + IDX_OUT_W'(1);
            end
         end else if (cmd.finish) begin
            out_ff    <= fin_data;
            out_v_ff  <= 1'b1;
            pend_v_ff <= 1'b0;
         end
      end
   end

   // Status back to the controller
   always_comb begin
      sts            = '0;
      sts.clear_last = &clr_cnt_ff;
      sts.mul_last   = mul_cnt_ff == 3'd4;
      sts.div_done   = div_done;
      sts.div_last   = div_idx_ff == 2'd3;
      sts.item_ok    = valid_ff && on_map(c_col) && on_map(c_row) &&
                       on_map(c_rcol) && on_map(c_rrow);
      sts.wr_ok      = !(evt && pend_v_ff && out_v_ff);
      sts.hit_mode   = hit_mode_ff;
      sts.walk_end   = end_ff;
      sts.out_free   = !out_v_ff;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
endmodule

// ----- rtl/ogru_ctrl.sv -----
// Controller: sequences clearing, transform, division, hit and walk per point
`timescale 1ns / 1ps
module ogru_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ogru_pkg::dp_status_type sts,
   output ogru_pkg::ctrl_cmd_type  cmd
);
   import ogru_pkg::*;

   ctrl_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:     if (sts.clear_last) state_in = ST_IDLE;
         ST_IDLE:      if (req_valid) state_in = ST_MUL;
         ST_MUL:       if (sts.mul_last) state_in = ST_WORLD;
         ST_WORLD:     state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (sts.div_done) begin
               state_in = sts.div_last ? ST_CHECK : ST_DIV_START;
            end
         end
         ST_CHECK:     state_in = sts.item_ok ? ST_SETUP : ST_FINISH;
         ST_SETUP:     state_in = ST_HIT_RD;
         ST_HIT_RD:    state_in = ST_WRITE;
         ST_WRITE: begin
            if (sts.wr_ok) begin
               state_in = (sts.hit_mode || !sts.walk_end) ? ST_STEP : ST_FINISH;
            end
         end
         ST_STEP:      state_in = ST_WRITE;
         ST_FINISH:    if (sts.out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR:     cmd.clear_wr = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MUL:       cmd.mul = 1'b1;
         ST_WORLD:     cmd.world = 1'b1;
         ST_DIV_START: cmd.div_start = 1'b1;
         ST_DIV_WAIT:  cmd.div_store = sts.div_done;
         ST_CHECK: begin
            cmd.check = sts.item_ok;
            cmd.drop  = !sts.item_ok;
         end
         ST_SETUP:     cmd.setup = 1'b1;
         ST_HIT_RD:    cmd.hit_rd = 1'b1;
         ST_WRITE:     cmd.write = sts.wr_ok;
         ST_STEP:      cmd.step = 1'b1;
         ST_FINISH:    cmd.finish = sts.out_free;
         default:      cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- rtl/occupancy_grid_ray_update.sv -----
// Top level: occupancy grid ray update with register port, controller and datapath
//
//   channel | direction | handshake             | carries
//   req_ch  | in        | valid / ready         | one scan point per transaction
//   rsp_ch  | out       | valid / ready         | one cell event per transaction
//   csr_*   | in        | psel/penable, pready  | heading, robot position, cell size
//
// After reset a clearing pass zeroes the map, one cell a cycle, over all
// 2**(2*clog2(MAP_CELLS)) cells (4096 by default); no point is taken meanwhile.
// Each point runs four serial cell-size divisions, then a read-modify-write of
// the hit cell and of each map cell walked (up to MAP_CELLS) through the single
// map memory. A stalled rsp_ch holds the walk at an event once the pending and
// output stages are both full; one point at a time.
`timescale 1ns / 1ps
module occupancy_grid_ray_update #(
   parameter int MAP_CELLS  = ogru_pkg::MAP_CELLS_DEF,
   parameter int MAP_CENTER = ogru_pkg::MAP_CENTER_DEF,
   parameter int CELL_BITS  = ogru_pkg::CELL_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   ogru_req_if.sink                      req_ch,
   ogru_rsp_if.source                    rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ogru_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [ogru_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [ogru_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import ogru_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   reg_idx_type     reg_idx;
   logic            csr_wr;
   ctrl_cmd_type    cmd;
   dp_status_type   sts;
   rsp_payload_type rsp_data;

   // Register port decode
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = reg_idx_type'(csr_paddr[CSR_AW-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (reg_idx)
            REG_HEADING_SIN:  cfg_in.heading_sin  = csr_pwdata[SIN_W-1:0];
            REG_HEADING_COS:  cfg_in.heading_cos  = csr_pwdata[SIN_W-1:0];
            REG_ROBOT_X_MM:   cfg_in.robot_x_mm   = csr_pwdata[POS_W-1:0];
            REG_ROBOT_Y_MM:   cfg_in.robot_y_mm   = csr_pwdata[POS_W-1:0];
            REG_CELL_SIZE_MM: cfg_in.cell_size_mm = csr_pwdata[CS_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_HEADING_SIN:  csr_prdata = CSR_DW'($unsigned(cfg_ff.heading_sin));
         REG_HEADING_COS:  csr_prdata = CSR_DW'($unsigned(cfg_ff.heading_cos));
         REG_ROBOT_X_MM:   csr_prdata = CSR_DW'($unsigned(cfg_ff.robot_x_mm));
         REG_ROBOT_Y_MM:   csr_prdata = CSR_DW'($unsigned(cfg_ff.robot_y_mm));
         REG_CELL_SIZE_MM: csr_prdata = CSR_DW'(cfg_ff.cell_size_mm);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heading_sin  <= '0;
         cfg_ff.heading_cos  <= SIN_W'(32767);
         cfg_ff.robot_x_mm   <= '0;
         cfg_ff.robot_y_mm   <= '0;
         cfg_ff.cell_size_mm <= CS_W'(50);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ogru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ogru_dp #(
      .MAP_CELLS  (MAP_CELLS),
      .MAP_CENTER (MAP_CENTER),
      .CELL_BITS  (CELL_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .cfg             (cfg_ff),
      .req_point_x_mm  (req_ch.point_x_mm),
      .req_point_y_mm  (req_ch.point_y_mm),
      .req_point_valid (req_ch.point_valid),
      .req_end_of_scan (req_ch.end_of_scan),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_data        (rsp_data)
   );

   // Response fields
   assign rsp_ch.cell_col      = rsp_data.cell_col;
   assign rsp_ch.cell_row      = rsp_data.cell_row;
   assign rsp_ch.event_kind    = rsp_data.event_kind;
   assign rsp_ch.event_index   = rsp_data.event_index;
   assign rsp_ch.last_of_point = rsp_data.last_of_point;
   assign rsp_ch.scan_done     = rsp_data.scan_done;
endmodule

// ----- rtl/ogru_checker.sv -----
// Checker on the top-level ports, bound to the occupancy grid ray update
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ogru_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [ogru_pkg::COL_W-1:0]       rsp_cell_col,
   input logic [ogru_pkg::COL_W-1:0]       rsp_cell_row,
   input logic [1:0]                       rsp_event_kind,
   input logic [ogru_pkg::IDX_OUT_W-1:0]   rsp_event_index,
   input logic                             rsp_last_of_point,
   input logic                             rsp_scan_done
);
   import ogru_pkg::*;

   // Hold a stalled response
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A dropped point gives one zeroed, final transaction
   `CHK_IMPLY(a_drop_single, clock, reset, rsp_valid && rsp_event_kind == KIND_DROP, rsp_last_of_point && rsp_cell_col == '0 && rsp_cell_row == '0 && rsp_event_index == '0)

   // Scan end only marks the final transaction of a point
   `CHK_IMPLY(a_scan_last, clock, reset, rsp_valid && rsp_scan_done, rsp_last_of_point)

   // No new point while events of the current one are still coming
   `CHK_IMPLY(a_no_accept_mid, clock, reset, rsp_valid && !rsp_last_of_point, !req_ready)
endmodule

bind occupancy_grid_ray_update ogru_checker u_ogru_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_cell_col      (rsp_ch.cell_col),
   .rsp_cell_row      (rsp_ch.cell_row),
   .rsp_event_kind    (rsp_ch.event_kind),
   .rsp_event_index   (rsp_ch.event_index),
   .rsp_last_of_point (rsp_ch.last_of_point),
   .rsp_scan_done     (rsp_ch.scan_done)
);
